FILE: design/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants for the increasing-subsequence finder.
// ----------------------------------------------------------------------------
package lis_pkg;

  // fixed port widths of the word fields
  localparam int FIELD_W = 16;
  localparam int LEN_W   = 6;

endpackage

FILE: design/lis_cell.sv
// ----------------------------------------------------------------------------
// lis_cell
// One candidate list. Cell K holds list K (K+1 values). It either takes
// the list of its left neighbor plus the new value, or swaps its own tail.
// ----------------------------------------------------------------------------
module lis_cell #(
  parameter int MAX_ELEMENTS = 32,
  parameter int VALUE_BITS   = 16,
  parameter int IW           = 5,
  parameter int CW           = 6,
  parameter int K            = 0
) (
  input  logic                                   clk,
  input  logic                                   step,
  input  logic                                   init,
  input  logic [VALUE_BITS-1:0]                  x,
  input  logic [IW-1:0]                          idx,
  input  logic [CW-1:0]                          count,
  input  logic [MAX_ELEMENTS-1:0][VALUE_BITS-1:0] left_row,
  output logic [MAX_ELEMENTS-1:0][VALUE_BITS-1:0] row,
  output logic                                   grow
);

  logic                                   do_tail;
  logic [MAX_ELEMENTS-1:0][VALUE_BITS-1:0] row_next;

  generate
    if (K == 0) begin : g_first
      // sole element of the one-element list
      assign do_tail = step && (idx == IW'(K)) && (x < row[K]);
      assign grow    = 1'b0;
      // only entry 0 is live here
      always_comb begin
        row_next    = '0;
        row_next[0] = (init || do_tail) ? x : row[0];
      end
    end else begin : g_rest
      logic do_load;
      // tail swap when x stays above the element before the tail
      assign do_tail = step && (idx == IW'(K)) && (x < row[K]) && (x > row[K-1]);
      // extension of the left list into this one
      assign do_load = step && (idx == IW'(K-1)) && (x > left_row[K-1]) &&
                       ((count == CW'(K)) || (x < row[K]));
      assign grow    = do_load && (count == CW'(K));
      always_comb begin
        row_next = row;
        if (do_load) begin
          row_next    = left_row;
          row_next[K] = x;
        end else if (do_tail) begin
          row_next[K] = x;
        end
      end
    end
  endgenerate

  // list register
  always_ff @(posedge clk) begin
    row <= row_next;
  end

endmodule

FILE: design/longest_increasing_subsequence.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Loads a sequence, then finds a strictly increasing subsequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (element_value, final_element) enter on in_valid/in_ready.
//   Up to MAX_ELEMENTS words are stored; later ones are dropped and flagged.
//   The word with final_element set starts the search, which runs on a row
//   of list cells, one cell visited per cycle from the longest list down.
//   Each element is first read from the store, then the live lists are
//   visited; the first element only seeds list 0. After the last element
//   the longest list is latched into the output buffer.
//   The result then leaves on out_valid/out_ready, one word per cycle,
//   result_last on the final word; out_ready low simply holds the word.
//   No input is taken from the final word until the last result word is
//   accepted. reverse_order (cfg_we/cfg_data) picks load or reverse order;
//   the user must write it only while idle; the block does not enforce it.
//   Reset (rst, synchronous) clears counts, flags, and the register.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence #(
  parameter int MAX_ELEMENTS = 32,
  parameter int VALUE_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lis_pkg::FIELD_W-1:0] element_value,
  input  logic                      final_element,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lis_pkg::FIELD_W-1:0] result_value,
  output logic                      result_last,
  output logic [lis_pkg::LEN_W-1:0] result_length,
  output logic                      overflowed
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {S_LOAD, S_READ, S_STEP, S_COPY, S_EMIT} state_t;
  typedef logic [MAX_ELEMENTS-1:0][VALUE_BITS-1:0] row_t;

  state_t          state;
  logic            reverse_order;
  logic [CW-1:0]   loaded;
  logic [CW-1:0]   count;
  logic [CW-1:0]   k;
  logic [IW-1:0]   i;
  logic [IW-1:0]   j;
  logic            ovf;
  logic [VALUE_BITS-1:0] xr;
  logic [VALUE_BITS-1:0] store [MAX_ELEMENTS];
  row_t            obuf;
  row_t            rows [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] grow_vec;
  logic [CW-1:0]   rd_idx;
  logic            step;
  logic            init;
  logic            grow;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign step      = (state == S_STEP) && (count != '0);
  assign init      = (state == S_STEP) && (count == '0);
  assign grow      = |grow_vec;
  assign rd_idx    = reverse_order ? (loaded - CW'(1) - k) : k;

  // result word
  assign result_value  = lis_pkg::FIELD_W'(obuf[j]);
  assign result_last   = ((CW'(j) + CW'(1)) == count);
  assign result_length = lis_pkg::LEN_W'(count);
  assign overflowed    = ovf;

  // row of list cells
  genvar g;
  generate
    for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
      row_t left;
      if (g == 0) begin : g_l0
        assign left = '0;
      end else begin : g_ln
        assign left = rows[g-1];
      end
      lis_cell #(
        .MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_BITS(VALUE_BITS),
        .IW(IW), .CW(CW), .K(g)
      ) u_cell (
        .clk(clk), .step(step), .init(init), .x(xr), .idx(i),
        .count(count), .left_row(left), .row(rows[g]), .grow(grow_vec[g])
      );
    end
  endgenerate

  // sequence store
  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_valid && loaded < CW'(MAX_ELEMENTS)) begin
      store[loaded[IW-1:0]] <= VALUE_BITS'(element_value);
    end
    if (state == S_READ) begin
      xr <= store[rd_idx[IW-1:0]];
    end
    if (state == S_COPY) begin
      obuf <= rows[IW'(count - CW'(1))];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      reverse_order <= 1'b0;
      loaded        <= '0;
      count         <= '0;
      k             <= '0;
      i             <= '0;
      j             <= '0;
      ovf           <= 1'b0;
    end else begin
      if (cfg_we) begin
        reverse_order <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (loaded < CW'(MAX_ELEMENTS)) begin
              loaded <= loaded + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (final_element) begin
              k     <= '0;
              count <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          i     <= IW'(count - CW'(1));
          state <= S_STEP;
        end
        S_STEP: begin
          if (init) begin
            count <= CW'(1);
          end else if (grow) begin
            count <= count + CW'(1);
          end
          if (init || i == '0) begin
            if (k + CW'(1) == loaded) begin
              state <= S_COPY;
            end else begin
              k     <= k + CW'(1);
              state <= S_READ;
            end
          end else begin
            i <= i - IW'(1);
          end
        end
        S_COPY: begin
          i     <= IW'(count - CW'(1));
          j     <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (result_last) begin
              loaded <= '0;
              count  <= '0;
              ovf    <= 1'b0;
              state  <= S_LOAD;
            end else begin
              j <= j + IW'(1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: dv/longest_increasing_subsequence_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_tb
// Sends random and directed sequences through the finder in both orders and
// checks every result word against a local candidate-list predictor.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_tb;

  localparam int MAX_EL    = 32;
  localparam int CYC_LIMIT = 2000000;

  typedef struct packed {
    logic [lis_pkg::FIELD_W-1:0] value;
    logic                        last;
    logic [lis_pkg::LEN_W-1:0]   length;
    logic                        ovf;
  } lis_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [lis_pkg::FIELD_W-1:0] element_value = '0;
  logic final_element = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lis_pkg::FIELD_W-1:0] result_value;
  logic result_last;
  logic [lis_pkg::LEN_W-1:0] result_length;
  logic overflowed;

  // predictor state
  logic [lis_pkg::FIELD_W-1:0] seq_mem [MAX_EL];
  logic [lis_pkg::FIELD_W-1:0] lists [MAX_EL][MAX_EL];
  int seq_len = 0;
  int n_lists = 0;
  bit ovf_flag = 0;
  bit rev_cfg = 0;

  lis_word_t subseq_q[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit rx_random = 1;

  longest_increasing_subsequence DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .element_value(element_value), .final_element(final_element),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .result_last(result_last),
    .result_length(result_length), .overflowed(overflowed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("longest_increasing_subsequence test failed");
      $finish;
    end
  end

  // fold one element into the candidate lists
  task automatic absorb_elem(input logic [lis_pkg::FIELD_W-1:0] x);
    int i;
    logic [lis_pkg::FIELD_W-1:0] tl;
    if (n_lists == 0) begin
      lists[0][0] = x;
      n_lists = 1;
      return;
    end
    for (i = n_lists - 1; i >= 0; i--) begin
      tl = lists[i][i];
      if (x > tl) begin
        if (i + 1 >= MAX_EL) continue;
        if (n_lists == i + 1) begin
          for (int j = 0; j <= i; j++) lists[i+1][j] = lists[i][j];
          lists[i+1][i+1] = x;
          n_lists = i + 2;
        end else if (x < lists[i+1][i+1]) begin
          for (int j = 0; j <= i; j++) lists[i+1][j] = lists[i][j];
          lists[i+1][i+1] = x;
        end
      end else if (x < tl) begin
        if (i == 0) lists[0][0] = x;
        else if (x > lists[i][i-1]) lists[i][i] = x;
      end
    end
  endtask

  // update predictor for one accepted word, queue the subsequence on final
  task automatic predict_subseq(input logic [lis_pkg::FIELD_W-1:0] v, input logic fin);
    lis_word_t w;
    if (seq_len < MAX_EL) begin
      seq_mem[seq_len] = v;
      seq_len++;
    end else begin
      ovf_flag = 1;
    end
    if (!fin) return;
    n_lists = 0;
    for (int k = 0; k < seq_len; k++)
      absorb_elem(seq_mem[rev_cfg ? seq_len - 1 - k : k]);
    for (int k = 0; k < n_lists; k++) begin
      w.value = lists[n_lists-1][k];
      w.last = (k + 1 == n_lists);
      w.length = n_lists[lis_pkg::LEN_W-1:0];
      w.ovf = ovf_flag;
      subseq_q = {subseq_q, w};
    end
    seq_len = 0;
    n_lists = 0;
    ovf_flag = 0;
  endtask

  // send one word with a random gap before it; valid drops only in a gap
  task automatic send_word(input logic [lis_pkg::FIELD_W-1:0] v, input logic fin);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element_value <= v;
    final_element <= fin;
    do @(posedge clk); while (!in_ready);
    predict_subseq(v, fin);
  endtask

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = rx_random ? $urandom_range(0, 4) : 0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    lis_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (subseq_q.size() == 0) begin
        $error("unexpected result word value=%0h", result_value);
        errors++;
      end else begin
        e = subseq_q.pop_front();
        if (result_value !== e.value) begin
          $error("result_value exp %0h got %0h", e.value, result_value); errors++;
        end
        if (result_last !== e.last) begin
          $error("result_last exp %0d got %0d", e.last, result_last); errors++;
        end
        if (result_length !== e.length) begin
          $error("result_length exp %0d got %0d", e.length, result_length); errors++;
        end
        if (overflowed !== e.ovf) begin
          $error("overflowed exp %0d got %0d", e.ovf, overflowed); errors++;
        end
      end
    end
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (subseq_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_order(input bit r);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    rev_cfg = r;
  endtask

  // random sequence of n words, value pool picked per sequence
  task automatic send_seq(input int n);
    int mode;
    logic [lis_pkg::FIELD_W-1:0] v;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = lis_pkg::FIELD_W'($urandom);
        1: v = lis_pkg::FIELD_W'($urandom_range(0, 7));
        default: v = lis_pkg::FIELD_W'(i * 3 + $urandom_range(0, 5));
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  task automatic test_directed;
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b1);
    send_word(16'h0003, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0002, 1'b0);
    send_word(16'h0004, 1'b1);
  endtask

  // 32 ascending words plus extras beyond capacity, final one dropped
  task automatic test_overflow;
    for (int i = 0; i < MAX_EL + 3; i++)
      send_word(16'(i * 100 + 1), i == MAX_EL + 2);
  endtask

  task automatic test_random;
    for (int s = 0; s < 8; s++)
      send_seq($urandom_range(1, 24));
  endtask

  task automatic test_backpressure;
    hold_cycles = 600;
    send_seq(8);
    send_seq(6);
    send_seq(5);
    drain();
    send_seq(10);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    write_order(1'b1);
    test_directed();
    test_overflow();
    test_random();
    test_backpressure();
    write_order(1'b0);
    test_random();
    drain();
    if (errors == 0)
      $display("longest_increasing_subsequence test passed");
    else
      $display("longest_increasing_subsequence test failed");
    $finish;
  end

endmodule
